@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the filter core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// a holds in the same cycle as b
`define CFD_ASSERT_SAME(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("same-cycle check failed");
// a in one cycle is followed by b in the next
`define CFD_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("next-cycle check failed");
`else
`define CFD_ASSERT_SAME(label, clk, rst_n, a, b)
`define CFD_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

@@ rtl/core/cfd_pkg.sv @@
// Types and constants of the complex decimating FIR core.
package cfd_pkg;

	// function code of an input request
	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_TAP    = 1'b1;

	// configuration register indexes
	localparam logic [0:0] CFG_TAP_COUNT = 1'b0;
	localparam logic [0:0] CFG_DECIM     = 1'b1;

	localparam int CFG_DW = 7;

	typedef struct packed {
		logic               func;
		logic signed [15:0] sample_i;
		logic signed [15:0] sample_q;
		logic [5:0]         tap_index;
		logic signed [15:0] tap_value;
	} item_t;

	typedef struct packed {
		logic signed [15:0] out_i;
		logic signed [15:0] out_q;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_ROUND,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic coef_wr;   // store one coefficient
		logic smp_wr;    // store one sample, clear accumulator
		logic mac_issue; // read one tap pair into the MAC pipe
		logic tap_ok;    // tap reaches a written sample
		logic round;     // round and saturate the sums
		logic load_out;  // move the result to the output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pipe_busy;
		logic out_free;
	} status_t;

endpackage

@@ rtl/core/cfd_ctrl.sv @@
// Controller: configuration, decimation phase, history fill and tap sequencing.
module cfd_ctrl #(
	parameter int NTAPS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic                         func,
	input  logic                         cfg_we,
	input  logic [0:0]                   cfg_idx,
	input  logic [cfd_pkg::CFG_DW-1:0]   cfg_wdata,
	input  cfd_pkg::status_t             sts,
	output cfd_pkg::cmd_t                cmd,
	output logic [((NTAPS > 1) ? $clog2(NTAPS) : 1)-1:0] tap_addr
);

	localparam int AW   = (NTAPS > 1) ? $clog2(NTAPS) : 1;
	localparam int CNTW = ($clog2(NTAPS + 1) > 7) ? $clog2(NTAPS + 1) : 7;

	cfd_pkg::state_t state_q, state_d;

	logic [6:0]      tap_count_q;
	logic [4:0]      decim_q;
	logic [3:0]      phase_q;
	logic [3:0]      fac_m1;
	logic [CNTW-1:0] fill_q;
	logic [CNTW-1:0] taps_q;
	logic [CNTW-1:0] t_q;
	logic [CNTW-1:0] t_nxt;
	logic [CNTW-1:0] taps_eff;
	logic            accept;
	logic            smp_acc;

	assign item_stall = (state_q != cfd_pkg::ST_IDLE);
	assign accept     = item_valid && (state_q == cfd_pkg::ST_IDLE);
	assign smp_acc    = accept && (func == cfd_pkg::FUNC_SAMPLE);
	assign t_nxt      = t_q + CNTW'(1);
	assign tap_addr   = t_q[AW-1:0];

	// tap count limited to the delay line depth
	assign taps_eff = (32'(tap_count_q) > NTAPS) ? CNTW'(NTAPS) : CNTW'(tap_count_q);

	// last phase value: factor zero acts as one, above sixteen as sixteen
	always_comb begin
		if (decim_q == 5'd0) begin
			fac_m1 = 4'd0;
		end else if (decim_q > 5'd16) begin
			fac_m1 = 4'd15;
		end else begin
			fac_m1 = 4'(decim_q - 5'd1);
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= 7'd64;
			decim_q     <= 5'd1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				cfd_pkg::CFG_TAP_COUNT: tap_count_q <= cfg_wdata[6:0];
				cfd_pkg::CFG_DECIM:     decim_q     <= cfg_wdata[4:0];
			endcase
		end
	end

	// sample bookkeeping and tap counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 4'd0;
			fill_q  <= '0;
			taps_q  <= '0;
			t_q     <= '0;
		end else begin
			if (smp_acc) begin
				if (fill_q != CNTW'(NTAPS)) begin
					fill_q <= fill_q + CNTW'(1);
				end
				phase_q <= (phase_q >= fac_m1) ? 4'd0 : phase_q + 4'd1;
				taps_q  <= taps_eff;
				t_q     <= '0;
			end else if (state_q == cfd_pkg::ST_MAC) begin
				t_q <= t_nxt;
			end
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cfd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			cfd_pkg::ST_IDLE: begin
				if (accept) begin
					if (func == cfd_pkg::FUNC_TAP) begin
						cmd.coef_wr = 1'b1;
					end else begin
						cmd.smp_wr = 1'b1;
						if (phase_q == 4'd0) begin
							state_d = (taps_eff == '0) ? cfd_pkg::ST_DRAIN : cfd_pkg::ST_MAC;
						end
					end
				end
			end
			cfd_pkg::ST_MAC: begin
				cmd.mac_issue = 1'b1;
				cmd.tap_ok    = (t_q < fill_q);
				if (t_nxt == taps_q) begin
					state_d = cfd_pkg::ST_DRAIN;
				end
			end
			cfd_pkg::ST_DRAIN: begin
				if (!sts.pipe_busy) begin
					state_d = cfd_pkg::ST_ROUND;
				end
			end
			cfd_pkg::ST_ROUND: begin
				cmd.round = 1'b1;
				state_d   = cfd_pkg::ST_DONE;
			end
			cfd_pkg::ST_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = cfd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cfd_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/core/cfd_dpath.sv @@
// Datapath: delay line and coefficient memories, MAC pipe, rounding, output register.
module cfd_dpath #(
	parameter int NTAPS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfd_pkg::item_t        item_data,
	input  cfd_pkg::cmd_t         cmd,
	input  logic [((NTAPS > 1) ? $clog2(NTAPS) : 1)-1:0] tap_addr,
	output cfd_pkg::status_t      sts,
	output logic                  res_valid,
	input  logic                  res_stall,
	output cfd_pkg::result_t      res_data
);

	localparam int AW   = (NTAPS > 1) ? $clog2(NTAPS) : 1;
	localparam int ACCW = 32 + AW;
	localparam logic [AW-1:0] LAST = AW'(NTAPS - 1);

	// rail sum scaled by 2^-15, rounded half away from zero, saturated
	function automatic logic signed [15:0] round_sat(input logic signed [ACCW-1:0] s);
		logic [ACCW-1:0] mag;
		logic [ACCW-1:0] rnd;
		logic [15:0]     r;
		mag = s[ACCW-1] ? (~s + ACCW'(1)) : s;
		rnd = (mag + ACCW'(16384)) >> 15;
		if (s[ACCW-1]) begin
			r = (rnd >= ACCW'(32768)) ? 16'h8000 : (~rnd[15:0] + 16'd1);
		end else begin
			r = (rnd > ACCW'(32767)) ? 16'h7fff : rnd[15:0];
		end
		return $signed(r);
	endfunction

	logic [31:0]              dl_mem [NTAPS];
	logic [15:0]              coef_mem [NTAPS];
	logic [AW-1:0]            wpos_q;
	logic [AW-1:0]            rd_q;
	logic [31:0]              smp_s1;
	logic signed [15:0]       coef_s1;
	logic                     v_s1;
	logic                     ok_s1;
	logic signed [31:0]       prod_i_s2;
	logic signed [31:0]       prod_q_s2;
	logic                     v_s2;
	logic signed [ACCW-1:0]   acc_i_q;
	logic signed [ACCW-1:0]   acc_q_q;
	logic signed [15:0]       rnd_i_q;
	logic signed [15:0]       rnd_q_q;
	logic                     res_valid_q;
	cfd_pkg::result_t         res_q;

	assign sts.pipe_busy = v_s1 || v_s2;
	assign sts.out_free  = !res_valid_q || !res_stall;
	assign res_valid     = res_valid_q;
	assign res_data      = res_q;

	// delay line memory: I in the upper half, Q in the lower
	always_ff @(posedge clk) begin
		if (cmd.smp_wr) begin
			dl_mem[wpos_q] <= {item_data.sample_i, item_data.sample_q};
		end
		if (cmd.mac_issue) begin
			smp_s1 <= dl_mem[rd_q];
		end
	end

	// coefficient memory, indexes past the depth are dropped
	always_ff @(posedge clk) begin
		if (cmd.coef_wr && (32'(item_data.tap_index) < NTAPS)) begin
			coef_mem[AW'(item_data.tap_index)] <= item_data.tap_value;
		end
		if (cmd.mac_issue) begin
			coef_s1 <= $signed(coef_mem[tap_addr]);
		end
	end

	// write and read pointers, read walks from newest to oldest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q <= '0;
			rd_q   <= '0;
		end else if (cmd.smp_wr) begin
			wpos_q <= (wpos_q == LAST) ? '0 : wpos_q + AW'(1);
			rd_q   <= wpos_q;
		end else if (cmd.mac_issue) begin
			rd_q <= (rd_q == '0) ? LAST : rd_q - AW'(1);
		end
	end

	// MAC pipe valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			ok_s1 <= 1'b0;
			v_s2  <= 1'b0;
		end else begin
			v_s1  <= cmd.mac_issue;
			ok_s1 <= cmd.tap_ok;
			v_s2  <= v_s1;
		end
	end

	// products; taps beyond the written history count as zero
	always_ff @(posedge clk) begin
		if (v_s1) begin
			prod_i_s2 <= ok_s1 ? coef_s1 * $signed(smp_s1[31:16]) : 32'sd0;
			prod_q_s2 <= ok_s1 ? coef_s1 * $signed(smp_s1[15:0]) : 32'sd0;
		end
	end

	// accumulators
	always_ff @(posedge clk) begin
		if (cmd.smp_wr) begin
			acc_i_q <= '0;
			acc_q_q <= '0;
		end else if (v_s2) begin
			acc_i_q <= acc_i_q + ACCW'(prod_i_s2);
			acc_q_q <= acc_q_q + ACCW'(prod_q_s2);
		end
	end

	// rounding stage
	always_ff @(posedge clk) begin
		if (cmd.round) begin
			rnd_i_q <= round_sat(acc_i_q);
			rnd_q_q <= round_sat(acc_q_q);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			res_q.out_i <= rnd_i_q;
			res_q.out_q <= rnd_q_q;
		end
	end

endmodule

@@ rtl/core/complex_fir_decimator_core.sv @@
// Top level of the complex decimating FIR core.
// Usage:
//   item channel (item_valid / item_stall / item_data): each request is either a
//   coefficient write (func = 1, tap_index / tap_value) or a complex sample
//   (func = 0, sample_i / sample_q). Both rails share the coefficients.
//   res channel (res_valid / res_stall / res_data): one filtered sample for
//   every decimation_factor-th input sample, starting with the first.
//   Config port (cfg_we / cfg_idx / cfg_wdata): index 0 tap_count, index 1
//   decimation_factor; write only while the core is idle.
// Timing:
//   Coefficient writes and samples that are decimated away do not raise item_stall.
//   An emitted sample holds item_stall high from its accepting edge while
//   min(tap_count, NTAPS) taps go one tap per cycle through the single shared
//   multiply-accumulate pipe, then through the drain, rounding and the output
//   load. res_valid rises as item_stall drops.
// Reset: unwritten history reads as zero, write position and phase clear,
//   tap_count = 64, decimation_factor = 1; coefficients must be loaded.
// Stall: a result held by res_stall stays in the output register; the core
//   keeps taking requests and only waits when the next result is ready.
`include "assert_macros.svh"

module complex_fir_decimator_core #(
	parameter int NTAPS = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  cfd_pkg::item_t             item_data,
	output logic                       res_valid,
	input  logic                       res_stall,
	output cfd_pkg::result_t           res_data,
	input  logic                       cfg_we,
	input  logic [0:0]                 cfg_idx,
	input  logic [cfd_pkg::CFG_DW-1:0] cfg_wdata
);

	localparam int AW = (NTAPS > 1) ? $clog2(NTAPS) : 1;

	cfd_pkg::cmd_t    cmd;
	cfd_pkg::status_t sts;
	logic [AW-1:0]    tap_addr;

	cfd_ctrl #(
		.NTAPS(NTAPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.func      (item_data.func),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.sts       (sts),
		.cmd       (cmd),
		.tap_addr  (tap_addr)
	);

	cfd_dpath #(
		.NTAPS(NTAPS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_data(item_data),
		.cmd      (cmd),
		.tap_addr (tap_addr),
		.sts      (sts),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data (res_data)
	);

	// a new result never overwrites one that is still waiting
	`CFD_ASSERT_SAME(a_load_free, clk, arst_n, cmd.load_out, sts.out_free)
	// no request is taken while taps are being issued
	`CFD_ASSERT_SAME(a_mac_stall, clk, arst_n, cmd.mac_issue, item_stall)
	// rounding only after the MAC pipe has drained
	`CFD_ASSERT_SAME(a_round_drained, clk, arst_n, cmd.round, !sts.pipe_busy)
	// a loaded result shows on the output next cycle
	`CFD_ASSERT_NEXT(a_load_valid, clk, arst_n, cmd.load_out, res_valid)

endmodule
